@@ rtl/url_percent_codec_unit_assert.svh @@
// Assertion macros shared by the codec checker.
`ifndef URL_PERCENT_CODEC_UNIT_ASSERT_SVH
`define URL_PERCENT_CODEC_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UPC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UPC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/upc_pkg.sv @@
// Shared types, character constants and byte classification functions for the codec.
`default_nettype none

package upc_pkg;

    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] HEX_ALPHA_OFS = 8'h37;  // 'A' - 10
    localparam logic [7:0] CASE_FOLD = 8'hDF;
    localparam logic [7:0] MASK_LO   = 8'h0F;

    // One queue entry: all result bytes of one input beat.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [1:0]                  count;
        logic                        last;
    } upc_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } upc_qstat_t;

    function automatic logic [7:0] hex_upper(input logic [3:0] nib);
        logic [7:0] wide;
        wide = {4'b0000, nib};
        return (nib > 4'd9) ? wide + HEX_ALPHA_OFS : wide + CH_ZERO;
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        logic hit;
        case (b) inside
            [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        if (b >= CH_UPPER_A)
            v = ((b & CASE_FOLD) - HEX_ALPHA_OFS) & MASK_LO;
        else
            v = (b - CH_ZERO) & MASK_LO;
        return v[3:0];
    endfunction

    // Unreserved set: letters, digits and - _ . ! ~ * ' ( )
    function automatic logic passes_plain(input logic [7:0] b);
        logic hit;
        case (b) inside
            [8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39],
            8'h2D, 8'h5F, 8'h2E, 8'h21, 8'h7E, 8'h2A, 8'h27, 8'h28, 8'h29: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage

`default_nettype wire

@@ rtl/upc_front.sv @@
// Front end: accepts input beats, holds the mode and decode state, builds result entries.
`default_nettype none

module upc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_wr_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [7:0]            in_byte,
    input  wire logic                  in_last,
    input  wire upc_pkg::upc_qstat_t   qstat,
    output logic                       push,
    output upc_pkg::upc_entry_t        push_entry
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_DIG  = 3'b100
    } upc_phase_t;

    logic       mode_reg;
    upc_phase_t phase_reg, phase_next;
    logic [7:0] held_reg, held_next;

    upc_pkg::upc_entry_t ent;
    logic [1:0]          n;
    logic                idle_path;
    logic                accept;

    assign in_stall = qstat.full;
    assign accept   = in_valid && !qstat.full;

    always_comb
    begin
        ent        = '0;
        n          = 2'd0;
        idle_path  = 1'b0;
        phase_next = phase_reg;
        held_next  = held_reg;
        if (!mode_reg)
        begin
            if (in_byte == upc_pkg::CH_SPACE)
            begin
                ent.bytes[n] = upc_pkg::CH_PLUS; n = n + 2'd1;
            end
            else if (upc_pkg::passes_plain(in_byte))
            begin
                ent.bytes[n] = in_byte; n = n + 2'd1;
            end
            else
            begin
                ent.bytes[n] = upc_pkg::CH_PCT; n = n + 2'd1;
                ent.bytes[n] = upc_pkg::hex_upper(in_byte[7:4]); n = n + 2'd1;
                ent.bytes[n] = upc_pkg::hex_upper(in_byte[3:0]); n = n + 2'd1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_PCT:
                begin
                    if (upc_pkg::is_hex(in_byte))
                    begin
                        held_next  = in_byte;
                        phase_next = PH_DIG;
                    end
                    else
                    begin
                        ent.bytes[n] = upc_pkg::CH_PCT; n = n + 2'd1;
                        idle_path = 1'b1;
                    end
                end
                PH_DIG:
                begin
                    if (upc_pkg::is_hex(in_byte))
                    begin
                        ent.bytes[n] = {upc_pkg::hex_value(held_reg),
                                        upc_pkg::hex_value(in_byte)};
                        n = n + 2'd1;
                        phase_next = PH_IDLE;
                        held_next  = '0;
                    end
                    else
                    begin
                        ent.bytes[n] = upc_pkg::CH_PCT; n = n + 2'd1;
                        ent.bytes[n] = held_reg; n = n + 2'd1;
                        held_next = '0;
                        idle_path = 1'b1;
                    end
                end
                default: idle_path = 1'b1;
            endcase
            // malformed escape falls back to plain handling of the current byte
            if (idle_path)
            begin
                phase_next = PH_IDLE;
                if (in_byte == upc_pkg::CH_PLUS)
                begin
                    ent.bytes[n] = upc_pkg::CH_SPACE; n = n + 2'd1;
                end
                else if (in_byte == upc_pkg::CH_PCT)
                    phase_next = PH_PCT;
                else
                begin
                    ent.bytes[n] = in_byte; n = n + 2'd1;
                end
            end
            // end of string flushes anything held
            if (in_last && phase_next != PH_IDLE)
            begin
                ent.bytes[n] = upc_pkg::CH_PCT; n = n + 2'd1;
                if (phase_next == PH_DIG)
                begin
                    ent.bytes[n] = held_next; n = n + 2'd1;
                end
                phase_next = PH_IDLE;
                held_next  = '0;
            end
        end
        ent.count = n;
        ent.last  = in_last;
    end

    assign push       = accept && (n != 2'd0);
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b0;
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg  <= cfg_wr_data;
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/upc_queue.sv @@
// Small entry queue between the front end and the output serializer.
`default_nettype none

module upc_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire upc_pkg::upc_entry_t  push_entry,
    input  wire logic                 pop,
    output upc_pkg::upc_entry_t       head,
    output upc_pkg::upc_qstat_t       qstat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    upc_pkg::upc_entry_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign qstat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign head        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? bump(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

@@ rtl/upc_back.sv @@
// Back end: walks the head entry into the output register, one byte per cycle when not stalled.
`default_nettype none

module upc_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire upc_pkg::upc_entry_t  head,
    input  wire upc_pkg::upc_qstat_t  qstat,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [7:0]                out_byte,
    output logic                      run_last,
    output logic                      stream_end
);

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       run_last_reg, run_last_next;
    logic       end_reg, end_next;
    logic [1:0] idx_reg, idx_next;
    logic       load;
    logic       at_end;

    assign load   = !valid_reg || !out_stall;
    assign at_end = (idx_reg == head.count - 2'd1);
    assign pop    = load && !qstat.empty && at_end;

    always_comb
    begin
        valid_next    = valid_reg;
        byte_next     = byte_reg;
        run_last_next = run_last_reg;
        end_next      = end_reg;
        idx_next      = idx_reg;
        if (load)
        begin
            valid_next = !qstat.empty;
            if (!qstat.empty)
            begin
                byte_next     = head.bytes[idx_reg];
                run_last_next = at_end;
                end_next      = at_end && head.last;
                idx_next      = at_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg     <= byte_next;
        run_last_reg <= run_last_next;
        end_reg      <= end_next;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign run_last   = run_last_reg;
    assign stream_end = end_reg;

endmodule

`default_nettype wire

@@ rtl/url_percent_codec_unit.sv @@
// Top level of the form-style percent encoder/decoder.
// Byte-stream codec for form-style percent encoding. cfg_wr_data written with cfg_wr_en picks
// encode (0) or decode (1) and clears any half-received escape. The output port delivers one
// byte per cycle while out_stall is low. An input beat makes one to three bytes when encoding
// and zero to three when decoding; a string of plain bytes streams at one beat per cycle while
// the output is not stalled. The front end classifies a beat in the cycle it is accepted and
// parks its result bytes in a QUEUE_DEPTH-entry queue, which is what lets input keep flowing
// while the output is stalled; a first byte goes via a queue slot to the output register.
// Beats that make no byte (the start of an escape) are absorbed without reaching the queue.
`default_nettype none

module url_percent_codec_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            run_last,
    output logic            stream_end
);

    upc_pkg::upc_entry_t push_entry;
    upc_pkg::upc_entry_t head;
    upc_pkg::upc_qstat_t qstat;
    logic                push;
    logic                pop;

    upc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .qstat       (qstat),
        .push        (push),
        .push_entry  (push_entry)
    );

    upc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    upc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

endmodule

`default_nettype wire

@@ rtl/upc_checker.sv @@
// Port-level checker for the codec, bound to the top level.
`default_nettype none

`include "url_percent_codec_unit_assert.svh"

module upc_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cfg_wr_en,
    input wire logic       cfg_wr_data,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] out_byte,
    input wire logic       run_last,
    input wire logic       stream_end
);

    logic mode_reg, mode_next;

    assign mode_next = cfg_wr_en ? cfg_wr_data : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else
            mode_reg <= mode_next;
    end

    `UPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_last) && $stable(stream_end), "stalled output beat changed")

    `UPC_ASSERT_NOW(a_end_is_run_last, out_valid && stream_end, run_last, "stream_end without run_last")

    // when encoding, a '%' always has two hex digits behind it
    `UPC_ASSERT_NOW(a_enc_pct_not_last, out_valid && !mode_reg && out_byte == upc_pkg::CH_PCT, !run_last, "encoded escape cut short")

    `UPC_ASSERT_NEXT(a_enc_digit_follows, out_valid && !out_stall && !mode_reg && !run_last, out_valid, "encoded escape has a gap")

endmodule

bind url_percent_codec_unit upc_checker u_upc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .run_last    (run_last),
    .stream_end  (stream_end)
);

`default_nettype wire
